>>> rtl/zcrd_pkg.sv
// Package for the Zadoff-Chu replica despreader: widths, the sequence state word,
// the quarter-wave cosine table and its lookup helpers.
// It depends on nothing else.
package zcrd_pkg;

  localparam int SEQ_LEN  = 139;
  localparam int TWO_N    = 2 * SEQ_LEN;
  localparam int FOUR_N   = 4 * SEQ_LEN;

  localparam int ROOT_W   = 10;
  localparam int SAMPLE_W = 16;
  localparam int POWER_W  = 36;
  localparam int INDEX_W  = 10;
  localparam int COS_W    = 16;

  localparam int POS_W    = (SEQ_LEN > 2) ? $clog2(SEQ_LEN) : 1;
  localparam int PH_W     = $clog2(TWO_N);
  localparam int N4_W     = $clog2(FOUR_N);
  localparam int QIDX_W   = $clog2(SEQ_LEN + 1);

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;
  localparam longint unsigned TWO_N_L = 64'(TWO_N);

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [PH_W-1:0]  acc;
    logic [PH_W-1:0]  inc;
  } seq_state_t;

  localparam int STATE_W = $bits(seq_state_t);

  typedef logic [COS_W-1:0] qrom_t [SEQ_LEN+1];

  // Q1.15 cosine of pi*m/(2N), built with a truncating Q30 Taylor series.
  function automatic logic [COS_W-1:0] cos_entry(input int unsigned m);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          r;
    int              k;
    x    = (PI_Q30 * 64'(m)) / TWO_N_L;
    x2   = (x * x) >> 30;
    term = ONE_Q30;
    sum  = longint'(ONE_Q30);
    for (k = 1; k <= 12; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      return '0;
    end
    r = (sum + 64'sd16384) >>> 15;
    if (r > 64'sd32767) begin
      r = 64'sd32767;
    end
    return COS_W'(r);
  endfunction

  function automatic qrom_t build_qrom();
    qrom_t q;
    for (int unsigned m = 0; m <= SEQ_LEN; m++) begin
      q[m] = cos_entry(m);
    end
    return q;
  endfunction

  localparam qrom_t QROM = build_qrom();

  // Full-circle cosine of pi*n/(2N) for n below 4N, from the quarter-wave table.
  function automatic logic signed [COS_W-1:0] circ_cos(input logic [N4_W-1:0] n);
    logic [QIDX_W-1:0] idx;
    logic              neg;
    priority if (32'(n) <= SEQ_LEN) begin
      idx = QIDX_W'(n);
      neg = 1'b0;
    end else if (32'(n) <= TWO_N) begin
      idx = QIDX_W'(TWO_N - 32'(n));
      neg = 1'b1;
    end else if (32'(n) <= 3 * SEQ_LEN) begin
      idx = QIDX_W'(32'(n) - TWO_N);
      neg = 1'b1;
    end else begin
      idx = QIDX_W'(FOUR_N - 32'(n));
      neg = 1'b0;
    end
    return neg ? -$signed(QROM[idx]) : $signed(QROM[idx]);
  endfunction

  // Twice the root reduced modulo 2N, by restoring compare and subtract.
  function automatic logic [PH_W-1:0] two_u_mod(input logic [ROOT_W-1:0] u);
    logic [ROOT_W-1:0] r;
    r = u;
    for (int k = ROOT_W - 1; k >= 0; k--) begin
      if (32'(r) >= (SEQ_LEN << k)) begin
        r = r - ROOT_W'(SEQ_LEN << k);
      end
    end
    return PH_W'({r, 1'b0});
  endfunction

endpackage

>>> rtl/zcrd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// It depends on nothing else.
module zcrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/zc_replica_despread_power_unit.sv
// Top level of the Zadoff-Chu replica despreader with per-sample power output.
// It depends on zcrd_pkg and on the generic RAM zcrd_ram.
//
//   channel | direction | handshake           | payload
//   in      | into      | in_valid/in_stall   | sample_re, sample_im, restart
//   out     | out of    | out_valid/out_stall | power, sample_index, last
//   cfg     | into      | cfg_valid/cfg_ready | root_index
//
// From its transfer to its result in the output register, a sample passes four steps:
// state read and table lookup, the four products, rounding and squares, the final sum.
// The sequence state is read from the state RAM once per sample and written back for all
// but the last of a sequence; one sample is in flight at a time, and a new one is taken in idle.
// After reset the root is 1 and the next sample has index zero; no clearing pass is run.
// A stalled output holds its result while the next sample is already taken.
module zc_replica_despread_power_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [zcrd_pkg::SAMPLE_W-1:0] sample_re_i,
  input  logic signed [zcrd_pkg::SAMPLE_W-1:0] sample_im_i,
  input  logic                                restart_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [zcrd_pkg::POWER_W-1:0]        power_o,
  output logic [zcrd_pkg::INDEX_W-1:0]        sample_index_o,
  output logic                                last_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [zcrd_pkg::ROOT_W-1:0]         root_index_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_SQ   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam int PW = zcrd_pkg::PH_W;
  localparam int NW = zcrd_pkg::N4_W;
  localparam int CW = zcrd_pkg::COS_W;
  localparam int SW = zcrd_pkg::SAMPLE_W;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       state_valid_q, state_valid_d;
  logic       slot_q, slot_d;
  logic [PW-1:0] twou_q, twou_d;

  logic signed [SW-1:0] a_q, b_q;
  logic                 restart_q;
  logic signed [CW-1:0] cv_q, sv_q;
  logic [zcrd_pkg::POS_W-1:0] pos_q;
  logic                 last_q;
  logic signed [31:0]   p_ac_q, p_bs_q, p_bc_q, p_as_q;
  logic [35:0]          sq_re_q, sq_im_q;
  logic [zcrd_pkg::POWER_W-1:0] power_q;
  logic [zcrd_pkg::INDEX_W-1:0] index_q;
  logic                 last_out_q;

  logic [zcrd_pkg::STATE_W-1:0] ram_rdata;
  logic                         ram_we;
  zcrd_pkg::seq_state_t         rd_state, cur, nxt;

  logic                 in_xfer, cfg_xfer, out_xfer, out_load;
  logic                 seq_rst, wrap, is_last;
  logic [NW-1:0]        n_cos, n_sin;
  logic [NW:0]          n_sin_sum;
  logic [PW:0]          acc_sum, inc_sum;
  logic signed [32:0]   re_p, im_p;
  logic signed [33:0]   re_b, im_b;
  logic signed [17:0]   re_r, im_r;
  logic signed [35:0]   sq_re_d, sq_im_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign out_xfer    = out_valid_q && !out_stall_i;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  zcrd_ram #(
    .WIDTH(zcrd_pkg::STATE_W),
    .DEPTH(2)
  ) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(~slot_q),
    .wdata_i(nxt),
    .raddr_i(slot_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    rd_state = zcrd_pkg::seq_state_t'(ram_rdata);
    seq_rst  = !state_valid_q || restart_q;
    cur.pos  = seq_rst ? '0 : rd_state.pos;
    cur.acc  = seq_rst ? '0 : rd_state.acc;
    cur.inc  = seq_rst ? twou_q : rd_state.inc;

    n_cos     = NW'({cur.acc, 1'b0});
    n_sin_sum = (NW+1)'(n_cos) + (NW+1)'(3 * zcrd_pkg::SEQ_LEN);
    n_sin     = (32'(n_sin_sum) >= zcrd_pkg::FOUR_N) ?
                NW'(32'(n_sin_sum) - zcrd_pkg::FOUR_N) : NW'(n_sin_sum);

    wrap    = 32'(cur.pos) >= zcrd_pkg::SEQ_LEN - 1;
    is_last = 32'(cur.pos) == zcrd_pkg::SEQ_LEN - 1;

    acc_sum = (PW+1)'(cur.acc) + (PW+1)'(cur.inc);
    inc_sum = (PW+1)'(cur.inc) + (PW+1)'(twou_q);
    nxt.pos = cur.pos + 1'b1;
    nxt.acc = (32'(acc_sum) >= zcrd_pkg::TWO_N) ?
              PW'(32'(acc_sum) - zcrd_pkg::TWO_N) : PW'(acc_sum);
    nxt.inc = (32'(inc_sum) >= zcrd_pkg::TWO_N) ?
              PW'(32'(inc_sum) - zcrd_pkg::TWO_N) : PW'(inc_sum);

    ram_we = (state_q == S_LOOK) && !wrap;
  end

  always_comb begin
    re_p    = 33'(p_ac_q) - 33'(p_bs_q);
    im_p    = 33'(p_bc_q) + 33'(p_as_q);
    re_b    = 34'(re_p) + 34'sd16384;
    im_b    = 34'(im_p) + 34'sd16384;
    re_r    = re_b[32:15];
    im_r    = im_b[32:15];
    sq_re_d = re_r * re_r;
    sq_im_d = im_r * im_r;
  end

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q;
    state_valid_d = state_valid_q;
    slot_d        = slot_q;
    twou_d        = twou_q;
    if (out_xfer) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_LOOK;
        end
        if (cfg_xfer) begin
          twou_d        = zcrd_pkg::two_u_mod(root_index_i);
          state_valid_d = 1'b0;
        end
      end
      S_LOOK: begin
        state_d       = S_MUL;
        state_valid_d = !wrap;
        if (ram_we) begin
          slot_d = ~slot_q;
        end
      end
      S_MUL: begin
        state_d = S_SQ;
      end
      S_SQ: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      state_valid_q <= 1'b0;
      slot_q        <= 1'b0;
      twou_q        <= PW'(2 % zcrd_pkg::TWO_N);
    end else begin
      state_q       <= state_d;
      out_valid_q   <= out_valid_d;
      state_valid_q <= state_valid_d;
      slot_q        <= slot_d;
      twou_q        <= twou_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      a_q       <= sample_re_i;
      b_q       <= sample_im_i;
      restart_q <= restart_i;
    end
    if (state_q == S_LOOK) begin
      cv_q   <= zcrd_pkg::circ_cos(n_cos);
      sv_q   <= zcrd_pkg::circ_cos(n_sin);
      pos_q  <= cur.pos;
      last_q <= is_last;
    end
    if (state_q == S_MUL) begin
      p_ac_q <= a_q * cv_q;
      p_bs_q <= b_q * sv_q;
      p_bc_q <= b_q * cv_q;
      p_as_q <= a_q * sv_q;
    end
    if (state_q == S_SQ) begin
      sq_re_q <= 36'(sq_re_d);
      sq_im_q <= 36'(sq_im_d);
    end
    if (out_load) begin
      power_q    <= zcrd_pkg::POWER_W'(sq_re_q + sq_im_q);
      index_q    <= zcrd_pkg::INDEX_W'(pos_q);
      last_out_q <= last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign power_o        = power_q;
  assign sample_index_o = index_q;
  assign last_o         = last_out_q;

  a_ram_we_in_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == S_LOOK)
    else $error("State RAM written outside the lookup cycle.");

  a_phase_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (32'(nxt.acc) < zcrd_pkg::TWO_N) && (32'(nxt.inc) < zcrd_pkg::TWO_N))
    else $error("Phase written back out of its modulo range.");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("Result appeared without passing the final stage.");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(sample_index_o) < zcrd_pkg::SEQ_LEN)
    else $error("Sample index beyond the sequence length.");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> 32'(sample_index_o) == zcrd_pkg::SEQ_LEN - 1)
    else $error("Last flag on a sample that does not end the sequence.");

endmodule
